>>> rtl/mscd_pkg.sv
// shared types and codes for the multi-slot countdown timer
package mscd_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int MAX_RESULTS    = 16;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_REAP   = 2'd2;
    localparam logic [1:0] ACT_TICK   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_EXPIRED = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    // one classified command beat between the front and the back
    typedef struct packed {
        logic [1:0]  action;
        logic        bad;     // negative count on add, slot out of range otherwise
        logic [14:0] secs;
        logic [7:0]  slot;
        logic [31:0] tag;
    } t_cmd;

endpackage

>>> rtl/mscd_front.sv
// command intake: classifies each beat and holds it in a two-entry queue
module mscd_front #(
    parameter int SLOTS = mscd_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_seconds,
    input  logic [7:0]         i_slot,
    input  logic [31:0]        i_tag,
    output logic               o_cmd_valid,
    output mscd_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);

    mscd_pkg::t_cmd r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       w_push;
    mscd_pkg::t_cmd w_new;
    logic       w_range_bad;

    assign busy        = (r_fill == 2'd2);
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    assign w_range_bad = ({1'b0, i_slot} >= 9'(SLOTS));

    always_comb begin
        w_new.action = i_action;
        w_new.secs   = i_seconds[14:0];
        w_new.slot   = i_slot;
        w_new.tag    = i_tag;
        if (i_action == mscd_pkg::ACT_ADD) begin
            w_new.bad = i_seconds[15];
        end else begin
            w_new.bad = w_range_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/mscd_back.sv
// slot table engine: busy/done flags, count and tag memories, result strobe
module mscd_back #(
    parameter int SLOTS      = mscd_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = mscd_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mscd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_strobe,
    output logic [2:0]     o_status,
    output logic [7:0]     o_slot_out,
    output logic [31:0]    o_tag_out,
    output logic           o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int XW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(mscd_pkg::MAX_RESULTS + 1);
    localparam logic [32:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [SLOTS-1:0]      r_busy, n_busy;
    logic [SLOTS-1:0]      r_done, n_done;
    logic [XW-1:0]         r_idx, n_idx;
    logic                  r_pv, n_pv;
    logic [IW-1:0]         r_pidx, n_pidx;
    logic [NW-1:0]         r_n, n_n;
    logic                  r_hv, n_hv;
    logic [IW-1:0]         r_hslot, n_hslot;
    logic [31:0]           r_htag, n_htag;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [31:0]           r_tag, n_tag;

    logic                  r_strobe, n_strobe;
    logic [2:0]            r_status, n_status;
    logic [7:0]            r_slot, n_slot;
    logic [31:0]           r_otag, n_otag;
    logic                  r_last, n_last;

    logic [COUNT_BITS-1:0] r_mem_cnt [SLOTS];
    logic [31:0]           r_mem_tag [SLOTS];
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic [31:0]           r_rd_tag;

    logic                  w_cnt_we, w_tag_we;
    logic [IW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic [IW-1:0]         w_raddr;
    logic [IW-1:0]         w_ci;
    logic [IW-1:0]         w_ai;
    logic [32:0]           w_s33;

    assign w_raddr = r_idx[IW-1:0];
    assign w_ci    = i_cmd.slot[IW-1:0];
    assign w_ai    = r_idx[IW-1:0];
    assign w_s33   = {18'd0, i_cmd.secs};

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_slot_out = r_slot;
    assign o_tag_out  = r_otag;
    assign o_last     = r_last;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_done      = r_done;
        n_idx       = r_idx;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_n         = r_n;
        n_hv        = r_hv;
        n_hslot     = r_hslot;
        n_htag      = r_htag;
        n_cnt       = r_cnt;
        n_tag       = r_tag;
        n_strobe    = 1'b0;
        n_status    = mscd_pkg::ST_OK;
        n_slot      = 8'd0;
        n_otag      = 32'd0;
        n_last      = 1'b0;
        w_cnt_we    = 1'b0;
        w_tag_we    = 1'b0;
        w_waddr     = r_pidx;
        w_cnt_wdata = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_idx = '0;
                    case (i_cmd.action)
                        mscd_pkg::ACT_ADD: begin
                            if (i_cmd.bad) begin
                                n_strobe = 1'b1;
                                n_status = mscd_pkg::ST_INVALID;
                                n_last   = 1'b1;
                            end else begin
                                n_cnt   = (w_s33 > CMAX) ? CMAX[COUNT_BITS-1:0]
                                                         : w_s33[COUNT_BITS-1:0];
                                n_tag   = i_cmd.tag;
                                n_state = S_ADD;
                            end
                        end
                        mscd_pkg::ACT_CANCEL: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (i_cmd.bad || !r_busy[w_ci]) begin
                                n_status = mscd_pkg::ST_INVALID;
                            end else begin
                                n_busy[w_ci] = 1'b0;
                                n_done[w_ci] = 1'b0;
                            end
                        end
                        mscd_pkg::ACT_REAP: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (i_cmd.bad) begin
                                n_status = mscd_pkg::ST_INVALID;
                            end else if (r_busy[w_ci] && r_done[w_ci]) begin
                                n_busy[w_ci] = 1'b0;
                                n_done[w_ci] = 1'b0;
                            end
                        end
                        default: begin
                            n_n     = '0;
                            n_hv    = 1'b0;
                            n_state = S_TICK;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (!r_busy[w_ai]) begin
                    n_busy[w_ai] = 1'b1;
                    n_done[w_ai] = 1'b0;
                    w_cnt_we     = 1'b1;
                    w_tag_we     = 1'b1;
                    w_waddr      = w_ai;
                    w_cnt_wdata  = r_cnt;
                    n_strobe     = 1'b1;
                    n_status     = mscd_pkg::ST_OK;
                    n_slot       = 8'(w_ai);
                    n_last       = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_idx == XW'(SLOTS - 1)) begin
                    n_strobe = 1'b1;
                    n_status = mscd_pkg::ST_NOSPACE;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + XW'(1);
                end
            end
            S_TICK: begin
                // read slot r_idx while slot r_pidx gets its data back
                if (r_idx < XW'(SLOTS)) begin
                    n_idx  = r_idx + XW'(1);
                    n_pv   = 1'b1;
                    n_pidx = w_raddr;
                end
                if (r_pv) begin
                    if (r_busy[r_pidx] && !r_done[r_pidx]) begin
                        if (r_rd_cnt <= COUNT_BITS'(1)) begin
                            if (r_n < NW'(mscd_pkg::MAX_RESULTS)) begin
                                n_done[r_pidx] = 1'b1;
                                n_n            = r_n + NW'(1);
                                // one expiry is held back until we know if it is the last
                                if (r_hv) begin
                                    n_strobe = 1'b1;
                                    n_status = mscd_pkg::ST_EXPIRED;
                                    n_slot   = 8'(r_hslot);
                                    n_otag   = r_htag;
                                end
                                n_hv    = 1'b1;
                                n_hslot = r_pidx;
                                n_htag  = r_rd_tag;
                            end else begin
                                w_cnt_we    = 1'b1;
                                w_cnt_wdata = COUNT_BITS'(1);
                            end
                        end else begin
                            w_cnt_we    = 1'b1;
                            w_cnt_wdata = r_rd_cnt - COUNT_BITS'(1);
                        end
                    end
                    if (r_pidx == IW'(SLOTS - 1)) begin
                        n_pv    = 1'b0;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                if (r_hv) begin
                    n_status = mscd_pkg::ST_EXPIRED;
                    n_slot   = 8'(r_hslot);
                    n_otag   = r_htag;
                end else begin
                    n_status = mscd_pkg::ST_IDLE;
                end
                n_hv    = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_mem_cnt[w_waddr] <= w_cnt_wdata;
        end
        if (w_tag_we) begin
            r_mem_tag[w_waddr] <= r_tag;
        end
        r_rd_cnt <= r_mem_cnt[w_raddr];
        r_rd_tag <= r_mem_tag[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= '0;
            r_done   <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_n      <= '0;
            r_hv     <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            r_n      <= n_n;
            r_hv     <= n_hv;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_hslot  <= n_hslot;
        r_htag   <= n_htag;
        r_cnt    <= n_cnt;
        r_tag    <= n_tag;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_otag   <= n_otag;
    end

endmodule

>>> rtl/multi_slot_countdown_timer.sv
// Table of SLOTS countdown timers. A command beat is taken when start is high and busy
// is low; up to two commands wait in a queue ahead of the slot engine, and busy is high
// only while that queue is full. Every command gives one or more results, each shown for
// one cycle with o_strobe, the final one with o_last; results cannot be held off. Cancel
// and reap are settled in the engine's idle state; add takes the command there, then the
// free-slot search steps through the busy flags one slot a cycle; a tick reads the count
// memory and writes it back one slot a cycle, the write-back trailing the registered
// read; a tick gives at most 16 expiries and further due slots fire on a later tick. No
// clearing pass after reset: counts and tags are only used for slots that an add has
// filled.
module multi_slot_countdown_timer #(
    parameter int SLOTS      = mscd_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = mscd_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_seconds,
    input  logic [7:0]         i_slot,
    input  logic [31:0]        i_tag,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [7:0]         o_slot_out,
    output logic [31:0]        o_tag_out,
    output logic               o_last
);

    logic           w_cmd_valid;
    logic           w_cmd_pop;
    mscd_pkg::t_cmd w_cmd;

    mscd_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_seconds   (i_seconds),
        .i_slot      (i_slot),
        .i_tag       (i_tag),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    mscd_back #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_slot_out  (o_slot_out),
        .o_tag_out   (o_tag_out),
        .o_last      (o_last)
    );

`ifndef NO_ASSERTIONS
    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_last)
        else $error("last flag without a result beat");

    a_more_only_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_status == mscd_pkg::ST_EXPIRED)
        else $error("non-final result that is not an expiry");

    a_tag_only_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != mscd_pkg::ST_EXPIRED |-> o_tag_out == 32'd0)
        else $error("tag on a result that is not an expiry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("queue filled without an accepted beat");
`endif

endmodule
